// ----- rtl/bptc_pkg.sv -----
// shared types and constants of the box projection texture coordinate generator
// no dependencies; imported by every module under rtl

package bptc_pkg;

   // fraction bits of the fixed point coordinates (q16.16)
   localparam int FRAC_BITS = 16;

   // default widths of the coordinate and normal fields
   localparam int COORD_WIDTH_DEF  = 32;
   localparam int NORMAL_WIDTH_DEF = 16;

   // 1.0 in q16.16, truncated to the coordinate width at use
   localparam logic [63:0] SCALE_ONE = 64'd1 << FRAC_BITS;

   // configuration register indexes
   typedef enum logic [1:0] {
      REG_OFFSET_U = 2'd0,
      REG_OFFSET_V = 2'd1,
      REG_SCALE_U  = 2'd2,
      REG_SCALE_V  = 2'd3
   } reg_index_type;

   // position component picked as a texture coordinate source
   typedef enum logic [1:0] {
      AXIS_X = 2'd0,
      AXIS_Y = 2'd1,
      AXIS_Z = 2'd2
   } axis_type;

   // per lane control that travels along the divider chain
   typedef struct packed {
      logic neg;   // result sign: dividend sign xor divisor sign
      logic ovf;   // quotient does not fit in the coordinate width
   } lane_ctl_type;

endpackage

// ----- rtl/bptc_front.sv -----
// front stage: dominant axis search, source selection, offset add and magnitude
// depends on bptc_pkg

module bptc_front import bptc_pkg::*; #(
   parameter int COORD_WIDTH  = COORD_WIDTH_DEF,
   parameter int NORMAL_WIDTH = NORMAL_WIDTH_DEF,
   parameter int REM_WIDTH    = COORD_WIDTH + 1 + FRAC_BITS
) (
   input  logic                    clock,
   input  logic                    enable,
   input  logic [COORD_WIDTH-1:0]  pos_x,
   input  logic [COORD_WIDTH-1:0]  pos_y,
   input  logic [COORD_WIDTH-1:0]  pos_z,
   input  logic [NORMAL_WIDTH-1:0] norm_x,
   input  logic [NORMAL_WIDTH-1:0] norm_y,
   input  logic [NORMAL_WIDTH-1:0] norm_z,
   input  logic [COORD_WIDTH-1:0]  offset_u,
   input  logic [COORD_WIDTH-1:0]  offset_v,
   input  logic                    scale_u_neg,
   input  logic                    scale_v_neg,
   output logic [REM_WIDTH-1:0]    u_rem,
   output logic [REM_WIDTH-1:0]    v_rem,
   output lane_ctl_type            u_ctl,
   output lane_ctl_type            v_ctl
);

   logic [NORMAL_WIDTH:0]  abs_x, abs_y, abs_z;
   logic                   pos_nx, pos_ny, pos_nz;
   axis_type               sel_u, sel_v;
   logic [COORD_WIDTH-1:0] src_u, src_v;
   logic [COORD_WIDTH:0]   sum_u, sum_v;
   logic [COORD_WIDTH:0]   mag_u, mag_v;
   logic [REM_WIDTH-1:0]   u_rem_ff, u_rem_in, v_rem_ff, v_rem_in;
   lane_ctl_type           u_ctl_ff, u_ctl_in, v_ctl_ff, v_ctl_in;

   // exact absolute values of the normal components
   assign abs_x = norm_x[NORMAL_WIDTH-1] ?
                  ((NORMAL_WIDTH+1)'(0) - {norm_x[NORMAL_WIDTH-1], norm_x}) : {1'b0, norm_x};
   assign abs_y = norm_y[NORMAL_WIDTH-1] ?
                  ((NORMAL_WIDTH+1)'(0) - {norm_y[NORMAL_WIDTH-1], norm_y}) : {1'b0, norm_y};
   assign abs_z = norm_z[NORMAL_WIDTH-1] ?
                  ((NORMAL_WIDTH+1)'(0) - {norm_z[NORMAL_WIDTH-1], norm_z}) : {1'b0, norm_z};

   // strictly positive components
   assign pos_nx = !norm_x[NORMAL_WIDTH-1] && (norm_x != '0);
   assign pos_ny = !norm_y[NORMAL_WIDTH-1] && (norm_y != '0);
   assign pos_nz = !norm_z[NORMAL_WIDTH-1] && (norm_z != '0);

   // dominant axis: x, then z, ties go to y
   always_comb begin
      priority if (abs_x > abs_y && abs_x > abs_z) begin
         sel_u = pos_nx ? AXIS_Y : AXIS_Z;
         sel_v = pos_nx ? AXIS_Z : AXIS_Y;
      end else if (abs_z > abs_x && abs_z > abs_y) begin
         sel_u = pos_nz ? AXIS_X : AXIS_Y;
         sel_v = pos_nz ? AXIS_Y : AXIS_X;
      end else begin
         sel_u = pos_ny ? AXIS_Z : AXIS_X;
         sel_v = pos_ny ? AXIS_X : AXIS_Z;
      end
   end

   // source component muxes
   always_comb begin
      unique case (sel_u)
         AXIS_X:  src_u = pos_x;
         AXIS_Y:  src_u = pos_y;
         AXIS_Z:  src_u = pos_z;
         default: src_u = pos_x;
      endcase
      unique case (sel_v)
         AXIS_X:  src_v = pos_x;
         AXIS_Y:  src_v = pos_y;
         AXIS_Z:  src_v = pos_z;
         default: src_v = pos_x;
      endcase
   end

   // offset add one bit wider, then magnitude
   assign sum_u = {src_u[COORD_WIDTH-1], src_u} + {offset_u[COORD_WIDTH-1], offset_u};
   assign sum_v = {src_v[COORD_WIDTH-1], src_v} + {offset_v[COORD_WIDTH-1], offset_v};
   assign mag_u = sum_u[COORD_WIDTH] ? ((COORD_WIDTH+1)'(0) - sum_u) : sum_u;
   assign mag_v = sum_v[COORD_WIDTH] ? ((COORD_WIDTH+1)'(0) - sum_v) : sum_v;

   // dividend is the magnitude scaled by 2^frac
   always_comb begin
      u_rem_in     = {mag_u, {FRAC_BITS{1'b0}}};
      v_rem_in     = {mag_v, {FRAC_BITS{1'b0}}};
      u_ctl_in.neg = sum_u[COORD_WIDTH] ^ scale_u_neg;
      u_ctl_in.ovf = 1'b0;
      v_ctl_in.neg = sum_v[COORD_WIDTH] ^ scale_v_neg;
      v_ctl_in.ovf = 1'b0;
   end

   // stage register
   always_ff @(posedge clock) begin
      if (enable) begin
         u_rem_ff <= u_rem_in;
         v_rem_ff <= v_rem_in;
         u_ctl_ff <= u_ctl_in;
         v_ctl_ff <= v_ctl_in;
      end
   end

   assign u_rem = u_rem_ff;
   assign v_rem = v_rem_ff;
   assign u_ctl = u_ctl_ff;
   assign v_ctl = v_ctl_ff;

endmodule

// ----- rtl/bptc_div_cell.sv -----
// one restoring division cell: decides one quotient bit and hands on the remainder
// depends on bptc_pkg

module bptc_div_cell import bptc_pkg::*; #(
   parameter int COORD_WIDTH = COORD_WIDTH_DEF,
   parameter int REM_WIDTH   = COORD_WIDTH + 1 + FRAC_BITS,
   parameter int BIT         = 0
) (
   input  logic                   clock,
   input  logic                   enable,
   input  logic [COORD_WIDTH-1:0] divisor,
   input  logic [REM_WIDTH-1:0]   src_rem,
   input  logic [COORD_WIDTH-1:0] src_quo,
   input  lane_ctl_type           src_ctl,
   output logic [REM_WIDTH-1:0]   dst_rem,
   output logic [COORD_WIDTH-1:0] dst_quo,
   output lane_ctl_type           dst_ctl
);

   localparam int DW = REM_WIDTH + COORD_WIDTH;

   logic [DW-1:0]          rem_ext, rem_hi, dvs_ext, diff;
   logic                   fits;
   logic [REM_WIDTH-1:0]   rem_ff, rem_in;
   logic [COORD_WIDTH-1:0] quo_ff, quo_in;
   lane_ctl_type           ctl_ff, ctl_in;

   // compare remainder against divisor weighted by 2^bit
   assign rem_ext = DW'(src_rem);
   assign dvs_ext = DW'(divisor);
   assign rem_hi  = rem_ext >> BIT;
   assign fits    = (rem_hi >= dvs_ext);
   assign diff    = rem_ext - (dvs_ext << BIT);
   assign rem_in  = fits ? diff[REM_WIDTH-1:0] : src_rem;

   // top cell flags an out of range quotient, the others set their bit
   generate
      if (BIT >= COORD_WIDTH) begin : g_ovf
         always_comb begin
            quo_in     = src_quo;
            ctl_in.neg = src_ctl.neg;
            ctl_in.ovf = src_ctl.ovf | fits;
         end
      end else begin : g_bit
         always_comb begin
            quo_in      = src_quo;
            quo_in[BIT] = fits;
            ctl_in      = src_ctl;
         end
      end
   endgenerate

   // cell register
   always_ff @(posedge clock) begin
      if (enable) begin
         rem_ff <= rem_in;
         quo_ff <= quo_in;
         ctl_ff <= ctl_in;
      end
   end

   assign dst_rem = rem_ff;
   assign dst_quo = quo_ff;
   assign dst_ctl = ctl_ff;

endmodule

// ----- rtl/box_projection_texcoord_gen_unit.sv -----
// Box projection texture coordinate generator. One vertex per clock is accepted while the
// pipeline is not held and one result per vertex is returned, in order; a vertex passes
// the front stage, COORD_WIDTH + 1 division cells and the output register. Both
// coordinates are divided in a chain of restoring division cells, one quotient bit per
// cell and cycle, so the chain length sets the latency while the rate stays one vertex
// per clock unless the pipeline holds. A skid register behind the output keeps req_tready
// registered; the pipeline holds whenever that skid register is occupied. Configuration
// is written through csr_* only while the unit is idle; the user must keep to this, the unit does not enforce it.
// Depends on bptc_pkg, bptc_front and bptc_div_cell.

module box_projection_texcoord_gen_unit import bptc_pkg::*; #(
   parameter int COORD_WIDTH  = COORD_WIDTH_DEF,
   parameter int NORMAL_WIDTH = NORMAL_WIDTH_DEF,
   localparam int REQ_BITS    = 3 * COORD_WIDTH + 3 * NORMAL_WIDTH,
   localparam int REQ_WIDTH   = ((REQ_BITS + 7) / 8) * 8,
   localparam int RSP_WIDTH   = ((2 * COORD_WIDTH + 7) / 8) * 8
) (
   input  logic                   clock,
   input  logic                   reset,
   // input vertex stream
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  logic [REQ_WIDTH-1:0]   req_tdata,   // pos_x, pos_y, pos_z, norm_x, norm_y, norm_z
   input  logic                   req_tlast,   // last_in
   // result stream
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output logic [RSP_WIDTH-1:0]   rsp_tdata,   // tex_u, tex_v
   output logic                   rsp_tuser,   // written
   output logic                   rsp_tlast,   // last_out
   // configuration writes
   input  logic                   csr_wr_en,
   input  logic [1:0]             csr_addr,
   input  logic [COORD_WIDTH-1:0] csr_wdata
);

   localparam int REM_WIDTH = COORD_WIDTH + 1 + FRAC_BITS;
   localparam int NCELL     = COORD_WIDTH + 1;
   localparam int NSTG      = NCELL + 1;
   localparam logic [COORD_WIDTH-1:0] LIM_POS = {1'b0, {(COORD_WIDTH-1){1'b1}}};
   localparam logic [COORD_WIDTH-1:0] LIM_NEG = {1'b1, {(COORD_WIDTH-1){1'b0}}};

   logic [COORD_WIDTH-1:0] offset_u_ff, offset_v_ff, scale_u_ff, scale_v_ff;
   logic [COORD_WIDTH-1:0] dvs_u, dvs_v;
   logic                   adv, push, pop;

   logic [REM_WIDTH-1:0]   rem_u [NSTG];
   logic [REM_WIDTH-1:0]   rem_v [NSTG];
   logic [COORD_WIDTH-1:0] quo_u [NSTG];
   logic [COORD_WIDTH-1:0] quo_v [NSTG];
   lane_ctl_type           ctl_u [NSTG];
   lane_ctl_type           ctl_v [NSTG];

   logic                   sb_valid_ff [NSTG];
   logic                   sb_written_ff [NSTG];
   logic                   sb_last_ff [NSTG];

   logic [COORD_WIDTH-1:0] lim_u, lim_v, sat_u, sat_v, res_u, res_v;
   logic [COORD_WIDTH-1:0] out_u_ff, out_v_ff, skid_u_ff, skid_v_ff;
   logic                   out_valid_ff, out_valid_in, skid_valid_ff, skid_valid_in;
   logic                   out_written_ff, out_last_ff, skid_written_ff, skid_last_ff;
   logic                   fin_written, fin_last;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         offset_u_ff <= '0;
         offset_v_ff <= '0;
         scale_u_ff  <= COORD_WIDTH'(SCALE_ONE);
         scale_v_ff  <= COORD_WIDTH'(SCALE_ONE);
      end else if (csr_wr_en) begin
         unique case (reg_index_type'(csr_addr))
            REG_OFFSET_U: offset_u_ff <= csr_wdata;
            REG_OFFSET_V: offset_v_ff <= csr_wdata;
            REG_SCALE_U:  scale_u_ff  <= csr_wdata;
            REG_SCALE_V:  scale_v_ff  <= csr_wdata;
            default:      offset_u_ff <= offset_u_ff;
         endcase
      end
   end

   // divisor magnitudes
   assign dvs_u = scale_u_ff[COORD_WIDTH-1] ? (COORD_WIDTH'(0) - scale_u_ff) : scale_u_ff;
   assign dvs_v = scale_v_ff[COORD_WIDTH-1] ? (COORD_WIDTH'(0) - scale_v_ff) : scale_v_ff;

   // whole pipeline moves unless the skid register is holding a result
   assign adv        = !skid_valid_ff;
   assign req_tready = adv;

   // front stage
   bptc_front #(
      .COORD_WIDTH  (COORD_WIDTH),
      .NORMAL_WIDTH (NORMAL_WIDTH),
      .REM_WIDTH    (REM_WIDTH)
   ) u_front (
      .clock       (clock),
      .enable      (adv),
      .pos_x       (req_tdata[COORD_WIDTH-1:0]),
      .pos_y       (req_tdata[2*COORD_WIDTH-1:COORD_WIDTH]),
      .pos_z       (req_tdata[3*COORD_WIDTH-1:2*COORD_WIDTH]),
      .norm_x      (req_tdata[3*COORD_WIDTH+NORMAL_WIDTH-1:3*COORD_WIDTH]),
      .norm_y      (req_tdata[3*COORD_WIDTH+2*NORMAL_WIDTH-1:3*COORD_WIDTH+NORMAL_WIDTH]),
      .norm_z      (req_tdata[3*COORD_WIDTH+3*NORMAL_WIDTH-1:3*COORD_WIDTH+2*NORMAL_WIDTH]),
      .offset_u    (offset_u_ff),
      .offset_v    (offset_v_ff),
      .scale_u_neg (scale_u_ff[COORD_WIDTH-1]),
      .scale_v_neg (scale_v_ff[COORD_WIDTH-1]),
      .u_rem       (rem_u[0]),
      .v_rem       (rem_v[0]),
      .u_ctl       (ctl_u[0]),
      .v_ctl       (ctl_v[0])
   );

   assign quo_u[0] = '0;
   assign quo_v[0] = '0;

   // division chain, most significant quotient weight first
   generate
      for (genvar k = 0; k < NCELL; k++) begin : g_cell
         bptc_div_cell #(
            .COORD_WIDTH (COORD_WIDTH),
            .REM_WIDTH   (REM_WIDTH),
            .BIT         (COORD_WIDTH - k)
         ) u_cell_u (
            .clock   (clock),
            .enable  (adv),
            .divisor (dvs_u),
            .src_rem (rem_u[k]),
            .src_quo (quo_u[k]),
            .src_ctl (ctl_u[k]),
            .dst_rem (rem_u[k+1]),
            .dst_quo (quo_u[k+1]),
            .dst_ctl (ctl_u[k+1])
         );
         bptc_div_cell #(
            .COORD_WIDTH (COORD_WIDTH),
            .REM_WIDTH   (REM_WIDTH),
            .BIT         (COORD_WIDTH - k)
         ) u_cell_v (
            .clock   (clock),
            .enable  (adv),
            .divisor (dvs_v),
            .src_rem (rem_v[k]),
            .src_quo (quo_v[k]),
            .src_ctl (ctl_v[k]),
            .dst_rem (rem_v[k+1]),
            .dst_quo (quo_v[k+1]),
            .dst_ctl (ctl_v[k+1])
         );
      end
   endgenerate

   // valid, written and last flags ride alongside the chain
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NSTG; i++) begin
            sb_valid_ff[i] <= 1'b0;
         end
      end else if (adv) begin
         sb_valid_ff[0] <= req_tvalid;
         for (int i = 1; i < NSTG; i++) begin
            sb_valid_ff[i] <= sb_valid_ff[i-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         sb_written_ff[0] <= (scale_u_ff != '0) && (scale_v_ff != '0);
         sb_last_ff[0]    <= req_tlast;
         for (int i = 1; i < NSTG; i++) begin
            sb_written_ff[i] <= sb_written_ff[i-1];
            sb_last_ff[i]    <= sb_last_ff[i-1];
         end
      end
   end

   // saturation and sign
   assign fin_written = sb_written_ff[NSTG-1];
   assign fin_last    = sb_last_ff[NSTG-1];

   always_comb begin
      lim_u = ctl_u[NSTG-1].neg ? LIM_NEG : LIM_POS;
      lim_v = ctl_v[NSTG-1].neg ? LIM_NEG : LIM_POS;
      sat_u = (ctl_u[NSTG-1].ovf || quo_u[NSTG-1] > lim_u) ? lim_u : quo_u[NSTG-1];
      sat_v = (ctl_v[NSTG-1].ovf || quo_v[NSTG-1] > lim_v) ? lim_v : quo_v[NSTG-1];
      res_u = ctl_u[NSTG-1].neg ? (COORD_WIDTH'(0) - sat_u) : sat_u;
      res_v = ctl_v[NSTG-1].neg ? (COORD_WIDTH'(0) - sat_v) : sat_v;
      if (!fin_written) begin
         res_u = '0;
         res_v = '0;
      end
   end

   // output register with skid stage
   assign push = adv && sb_valid_ff[NSTG-1];
   assign pop  = out_valid_ff && rsp_tready;

   always_comb begin
      out_valid_in  = out_valid_ff;
      skid_valid_in = skid_valid_ff;
      if (skid_valid_ff) begin
         if (pop) begin
            skid_valid_in = 1'b0;
         end
      end else if (push) begin
         if (out_valid_ff && !pop) begin
            skid_valid_in = 1'b1;
         end else begin
            out_valid_in = 1'b1;
         end
      end else if (pop) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (skid_valid_ff) begin
         if (pop) begin
            out_u_ff       <= skid_u_ff;
            out_v_ff       <= skid_v_ff;
            out_written_ff <= skid_written_ff;
            out_last_ff    <= skid_last_ff;
         end
      end else if (push) begin
         if (out_valid_ff && !pop) begin
            skid_u_ff       <= res_u;
            skid_v_ff       <= res_v;
            skid_written_ff <= fin_written;
            skid_last_ff    <= fin_last;
         end else begin
            out_u_ff       <= res_u;
            out_v_ff       <= res_v;
            out_written_ff <= fin_written;
            out_last_ff    <= fin_last;
         end
      end
   end

   // result transaction
   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = RSP_WIDTH'({out_v_ff, out_u_ff});
   assign rsp_tuser  = out_written_ff;
   assign rsp_tlast  = out_last_ff;

endmodule
